// ----- design/cac_pkg.sv -----
// Shared types, action codes and helpers for the complex add/compare unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package cac_pkg;

    localparam int SQ_CELLS = 32;   // one root bit per cell
    localparam int DV_CELLS = 32;   // one quotient bit per cell

    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ACT_ADD  = 2'd0,
        ACT_EQ   = 2'd1,
        ACT_MOD  = 2'd2,
        ACT_PROJ = 2'd3
    } t_act;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        sat;
        logic        zdiv;
    } t_res;

    // side band carried along the square-root chain
    typedef struct packed {
        logic               valid;
        t_act               act;
        logic signed [64:0] dot;
        t_res               res;
    } t_sq_side;

    // side band carried along the divider chain
    typedef struct packed {
        logic        valid;
        t_act        act;
        logic        neg;
        logic        big;    // quotient >= 2^32
        logic [31:0] norm;
        t_res        res;
    } t_dv_side;

    // saturate a 33-bit sum to 32 bits; bit 32 of the result is the clip flag
    function automatic logic [32:0] sat33(input logic [32:0] s);
        logic [32:0] r;
        begin
            if (s[32] == s[31]) begin
                r = {1'b0, s[31:0]};
            end else if (s[32]) begin
                r = {1'b1, SMIN};
            end else begin
                r = {1'b1, SMAX};
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/cac_sqrt_cell.sv -----
// One cell of the integer square-root chain: retires one root bit per cycle while i_en is high.
// Depends on cac_pkg.
`default_nettype none
module cac_sqrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [34:0]        i_rem,
    input  wire logic [31:0]        i_root,
    input  wire logic [63:0]        i_x,
    input  wire cac_pkg::t_sq_side  i_side,
    output logic [34:0]             o_rem,
    output logic [31:0]             o_root,
    output logic [63:0]             o_x,
    output cac_pkg::t_sq_side       o_side
);
    import cac_pkg::*;

    logic [34:0] w_r2;
    logic [34:0] w_trial;
    logic        w_ge;
    logic [34:0] n_rem;
    logic [31:0] n_root;
    logic [63:0] n_x;

    t_sq_side    r_side;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [63:0] r_x;

    always_comb begin
        w_r2    = {i_rem[32:0], i_x[63:62]};
        w_trial = {1'b0, i_root, 2'b01};
        w_ge    = (w_r2 >= w_trial);
        n_rem   = w_ge ? (w_r2 - w_trial) : w_r2;
        n_root  = {i_root[30:0], w_ge};
        n_x     = {i_x[61:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_x    <= n_x;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_x    = r_x;
    assign o_side = r_side;
endmodule
`default_nettype wire

// ----- design/cac_div_cell.sv -----
// One cell of the restoring divider chain: retires one quotient bit per cycle while i_en is high.
// Depends on cac_pkg.
`default_nettype none
module cac_div_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [31:0]        i_rem,
    input  wire logic [31:0]        i_low,
    input  wire logic [31:0]        i_q,
    input  wire cac_pkg::t_dv_side  i_side,
    output logic [31:0]             o_rem,
    output logic [31:0]             o_low,
    output logic [31:0]             o_q,
    output cac_pkg::t_dv_side       o_side
);
    import cac_pkg::*;

    logic [32:0] w_r2;
    logic [32:0] w_dvs;
    logic        w_ge;
    logic [32:0] w_diff;
    logic [31:0] n_rem;

    t_dv_side    r_side;
    logic [31:0] r_rem;
    logic [31:0] r_low;
    logic [31:0] r_q;

    always_comb begin
        w_r2   = {i_rem, i_low[31]};
        w_dvs  = {1'b0, i_side.norm};
        w_ge   = (w_r2 >= w_dvs);
        w_diff = w_r2 - w_dvs;
        n_rem  = w_ge ? w_diff[31:0] : w_r2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_low  <= {i_low[30:0], 1'b0};
            r_q    <= {i_q[30:0], w_ge};
        end
    end

    assign o_rem  = r_rem;
    assign o_low  = r_low;
    assign o_q    = r_q;
    assign o_side = r_side;
endmodule
`default_nettype wire

// ----- design/complex_add_compare_project.sv -----
// Top level of the fixed-point complex add/compare unit.
// Depends on cac_pkg, cac_sqrt_cell and cac_div_cell.
`default_nettype none
// Fully pipelined complex arithmetic on signed fixed-point operands: one transfer
// is taken per cycle while s_axis_tready is high, and results leave in order, one
// per input. The path from input to output runs through 69 register stages:
// input register, multiply, sum, 32 square-root cells, a normalize stage, 32
// divider cells and the output register.
// The length is set by the two bit-per-cell chains (root of |x|^2, then the
// quotient dot/|b|). A skid register behind the output register lets the pipe
// keep moving while one result waits; s_axis_tready drops only while it is full.
// Actions (tuser): add saturates per component, equal sets equal_flag, modulus
// gives floor(|a|), projection gives (a.b)/floor(|b|) truncated toward zero;
// b = 0 sets zero_divisor with a zero result.
module complex_add_compare_project (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // a_re, a_im, b_re, b_im (low to high)
    input  wire logic [1:0]   i_s_axis_tuser,  // action
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [63:0]       o_m_axis_tdata,  // result_re, result_im (low to high)
    output logic [2:0]        o_m_axis_tuser   // equal_flag, saturated, zero_divisor
);
    import cac_pkg::*;

    logic w_en;     // whole pipe advances together

    // ---- stage 1: input register
    logic        r1_v;
    t_act        r1_act;
    logic [31:0] r1_ar, r1_ai, r1_br, r1_bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v   <= i_s_axis_tvalid;
            r1_act <= t_act'(i_s_axis_tuser);
            r1_ar  <= i_s_axis_tdata[31:0];
            r1_ai  <= i_s_axis_tdata[63:32];
            r1_br  <= i_s_axis_tdata[95:64];
            r1_bi  <= i_s_axis_tdata[127:96];
        end
    end

    // ---- stage 2: products, add and equal results
    logic               r2_v;
    t_act               r2_act;
    logic signed [63:0] r2_px, r2_py, r2_pa, r2_pb;
    t_res               r2_res;
    logic [31:0]        w_xr, w_xi;
    logic [32:0]        w_sre, w_sim;
    t_res               w_res1;

    always_comb begin
        // modulus takes the root of |a|^2, projection of |b|^2
        w_xr  = (r1_act == ACT_MOD) ? r1_ar : r1_br;
        w_xi  = (r1_act == ACT_MOD) ? r1_ai : r1_bi;
        w_sre = sat33({r1_ar[31], r1_ar} + {r1_br[31], r1_br});
        w_sim = sat33({r1_ai[31], r1_ai} + {r1_bi[31], r1_bi});
        w_res1 = '0;
        unique case (r1_act)
            ACT_ADD: begin
                w_res1.re  = w_sre[31:0];
                w_res1.im  = w_sim[31:0];
                w_res1.sat = w_sre[32] | w_sim[32];
            end
            ACT_EQ: begin
                w_res1.eq = (r1_ar == r1_br) && (r1_ai == r1_bi);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v   <= r1_v;
            r2_act <= r1_act;
            r2_px  <= $signed(w_xr) * $signed(w_xr);
            r2_py  <= $signed(w_xi) * $signed(w_xi);
            r2_pa  <= $signed(r1_ar) * $signed(r1_br);
            r2_pb  <= $signed(r1_ai) * $signed(r1_bi);
            r2_res <= w_res1;
        end
    end

    // ---- stage 3: squared norm and dot product
    logic [63:0] r3_n2;
    t_sq_side    r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_side.valid <= 1'b0;
        end else if (w_en) begin
            r3_side.valid <= r2_v;
            r3_n2         <= r2_px + r2_py;   // both nonnegative, sum <= 2^63
            r3_side.act   <= r2_act;
            r3_side.dot   <= {r2_pa[63], r2_pa} + {r2_pb[63], r2_pb};
            r3_side.res   <= r2_res;
        end
    end

    // ---- square-root chain
    logic [34:0] sq_rem  [0:SQ_CELLS];
    logic [31:0] sq_root [0:SQ_CELLS];
    logic [63:0] sq_x    [0:SQ_CELLS];
    t_sq_side    sq_side [0:SQ_CELLS];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_x[0]    = r3_n2;
    assign sq_side[0] = r3_side;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        cac_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .i_x     (sq_x[g]),
            .i_side  (sq_side[g]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1]),
            .o_x     (sq_x[g+1]),
            .o_side  (sq_side[g+1])
        );
    end

    // ---- normalize stage: modulus result, dividend magnitude, overflow check
    t_sq_side    w_sq;
    logic [31:0] w_root;
    logic [64:0] w_mag65;
    logic [63:0] w_mag;
    t_dv_side    w_dv;

    always_comb begin
        w_sq    = sq_side[SQ_CELLS];
        w_root  = sq_root[SQ_CELLS];
        w_mag65 = w_sq.dot[64] ? (~w_sq.dot + 65'd1) : w_sq.dot;
        w_mag   = w_mag65[63:0];
        w_dv.valid = w_sq.valid;
        w_dv.act   = w_sq.act;
        w_dv.neg   = w_sq.dot[64];
        w_dv.norm  = w_root;
        w_dv.big   = (w_mag[63:32] >= w_root);
        w_dv.res   = w_sq.res;
        if (w_sq.act == ACT_MOD) begin
            w_dv.res.sat = w_root[31];
            w_dv.res.re  = w_root[31] ? SMAX : w_root;
        end
        if (w_sq.act == ACT_PROJ) begin
            w_dv.res.zdiv = (w_root == 32'd0);
        end
    end

    logic [31:0] r4_rem, r4_low;
    t_dv_side    r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_side.valid <= 1'b0;
        end else if (w_en) begin
            r4_side <= w_dv;
            r4_rem  <= w_mag[63:32];
            r4_low  <= w_mag[31:0];
        end
    end

    // ---- divider chain
    logic [31:0] dv_rem  [0:DV_CELLS];
    logic [31:0] dv_low  [0:DV_CELLS];
    logic [31:0] dv_q    [0:DV_CELLS];
    t_dv_side    dv_side [0:DV_CELLS];

    assign dv_rem[0]  = r4_rem;
    assign dv_low[0]  = r4_low;
    assign dv_q[0]    = '0;
    assign dv_side[0] = r4_side;

    for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
        cac_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_rem   (dv_rem[g]),
            .i_low   (dv_low[g]),
            .i_q     (dv_q[g]),
            .i_side  (dv_side[g]),
            .o_rem   (dv_rem[g+1]),
            .o_low   (dv_low[g+1]),
            .o_q     (dv_q[g+1]),
            .o_side  (dv_side[g+1])
        );
    end

    // ---- final stage: sign and saturate the projection
    t_dv_side    w_fin;
    logic [31:0] w_q;
    t_res        w_out;
    logic        w_pv;

    always_comb begin
        w_fin = dv_side[DV_CELLS];
        w_q   = dv_q[DV_CELLS];
        w_pv  = w_fin.valid;
        w_out = w_fin.res;
        if (w_fin.act == ACT_PROJ && !w_fin.res.zdiv) begin
            if (w_fin.big) begin
                w_out.sat = 1'b1;
                w_out.re  = w_fin.neg ? SMIN : SMAX;
            end else if (w_fin.neg) begin
                w_out.sat = (w_q > SMIN);
                w_out.re  = (w_q > SMIN) ? SMIN : (~w_q + 32'd1);
            end else begin
                w_out.sat = w_q[31];
                w_out.re  = w_q[31] ? SMAX : w_q;
            end
        end
    end

    // ---- output register with skid
    logic r_out_v, r_skid_v;
    t_res r_out, r_skid;

    assign w_en = !r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_axis_tready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out   <= w_out;
                r_out_v <= w_pv;
            end
        end else if (w_pv && w_en) begin
            r_skid   <= w_out;
            r_skid_v <= 1'b1;
        end
    end

    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out.im, r_out.re};
    assign o_m_axis_tuser  = {r_out.zdiv, r_out.sat, r_out.eq};

    // ---- checks
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    a_zdiv_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.zdiv) |-> (r_out.re == 32'd0 && !r_out.sat && !r_out.eq))
        else $error("zero divisor result not cleared");

    a_eq_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.eq) |-> (r_out.re == 32'd0 && r_out.im == 32'd0 && !r_out.sat))
        else $error("equal result carries data");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_axis_tready && !r_skid_v && w_pv) |=> r_skid_v)
        else $error("pipe result dropped while output stalled");
endmodule
`default_nettype wire

// ----- tb/complex_add_compare_project_tb.sv -----
// Self-checking testbench for the complex add/compare unit.
// Depends on cac_pkg and complex_add_compare_project, and through it on cac_sqrt_cell and cac_div_cell.
`default_nettype none
module complex_add_compare_project_tb;
    import cac_pkg::*;

    // Result fields in the order they leave the block.
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        sat;
        logic        zdiv;
    } t_cplx_res;

    // One row of the directed table; chk marks rows with a typed-in answer.
    typedef struct {
        t_act        act;
        logic [31:0] ar, ai, br, bi;
        bit          chk;
        t_cplx_res   res;
    } t_vec;

    localparam int PIPE_LAT = 70;
    localparam int WDOG_MAX = 20000;
    localparam int N_RAND   = 1650;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    t_cplx_res expected_q[$];
    int        n_err = 0;
    int        idle_cnt = 0;
    int        snd_idle_pct = 0;    // sender idle rate, percent
    int        rcv_idle_pct = 0;    // receiver idle rate, percent
    bit        hold_rcv = 1'b0;     // long receiver hold-off

    always #5 i_clk = ~i_clk;

    complex_add_compare_project DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // a_re, a_im, b_re, b_im (low to high)
        .i_s_axis_tuser  (s_tuser),   // action
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // result_re, result_im (low to high)
        .o_m_axis_tuser  (m_tuser)    // equal_flag, saturated, zero_divisor
    );

    // floor(sqrt(x)), bit by bit
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] rt, bitv, r;
        begin
            rt = 0;
            r = x;
            bitv = 64'd1 << 62;
            while (bitv > r) bitv >>= 2;
            while (bitv != 0) begin
                if (r >= rt + bitv) begin
                    r -= rt + bitv;
                    rt = (rt >> 1) + bitv;
                end else begin
                    rt >>= 1;
                end
                bitv >>= 2;
            end
            return rt;
        end
    endfunction

    // Computes the expected result of one transfer.
    function automatic t_cplx_res complex_result(input t_act act,
            input logic [31:0] ar, ai, br, bi);
        t_cplx_res r;
        logic signed [63:0] sr, si, a_r, a_i, b_r, b_i;
        logic signed [65:0] dot;
        logic [65:0] mag;
        logic [63:0] nrm, q;
        begin
            r = '{32'd0, 32'd0, 1'b0, 1'b0, 1'b0};
            a_r = $signed(ar); a_i = $signed(ai);
            b_r = $signed(br); b_i = $signed(bi);
            case (act)
                ACT_ADD: begin
                    sr = a_r + b_r;
                    si = a_i + b_i;
                    if (sr > 64'sh7FFF_FFFF) begin r.re = SMAX; r.sat = 1; end
                    else if (sr < -64'sh8000_0000) begin r.re = SMIN; r.sat = 1; end
                    else r.re = sr[31:0];
                    if (si > 64'sh7FFF_FFFF) begin r.im = SMAX; r.sat = 1; end
                    else if (si < -64'sh8000_0000) begin r.im = SMIN; r.sat = 1; end
                    else r.im = si[31:0];
                end
                ACT_EQ: r.eq = (ar == br) && (ai == bi);
                ACT_MOD: begin
                    // sum of squares fits 64 bits unsigned (at most 2^63)
                    nrm = isqrt(64'(a_r * a_r) + 64'(a_i * a_i));
                    if (nrm > 64'h7FFF_FFFF) begin r.re = SMAX; r.sat = 1; end
                    else r.re = nrm[31:0];
                end
                default: begin
                    nrm = isqrt(64'(b_r * b_r) + 64'(b_i * b_i));
                    if (nrm == 0) begin
                        r.zdiv = 1;
                    end else begin
                        dot = 66'(a_r * b_r) + 66'(a_i * b_i);
                        mag = dot[65] ? 66'(-dot) : 66'(dot);
                        q = 64'(mag / nrm);
                        if (dot[65]) begin
                            if (q > 64'h8000_0000) begin r.re = SMIN; r.sat = 1; end
                            else r.re = 32'(-q);
                        end else begin
                            if (q > 64'h7FFF_FFFF) begin r.re = SMAX; r.sat = 1; end
                            else r.re = q[31:0];
                        end
                    end
                end
            endcase
            return r;
        end
    endfunction

    // Operand values biased toward extremes and small numbers.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
            default: return $urandom;
        endcase
    endfunction

    // Offers one transfer and waits for it to be taken; valid stays up
    // into the next call unless the sender idles.
    task automatic send_item(input t_act act, input logic [31:0] ar, ai, br, bi,
            input bit chk, input t_cplx_res want);
        begin
            while ($urandom_range(0, 99) < snd_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= act;
            s_tdata  <= {bi, br, ai, ar};
            expected_q.push_back(chk ? want : complex_result(act, ar, ai, br, bi));
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    // Receiver: random backpressure, or held low for a stretch.
    always @(negedge i_clk) begin
        m_tready <= !hold_rcv && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Result check and watchdog.
    always @(posedge i_clk) begin
        t_cplx_res want;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_MAX) begin
                $display("CHECK FAILED");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    n_err = n_err + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.re) begin
                        $error("result_re exp %h got %h", want.re, m_tdata[31:0]);
                        n_err = n_err + 1;
                    end
                    if (m_tdata[63:32] !== want.im) begin
                        $error("result_im exp %h got %h", want.im, m_tdata[63:32]);
                        n_err = n_err + 1;
                    end
                    if (m_tuser[0] !== want.eq) begin
                        $error("equal_flag exp %b got %b", want.eq, m_tuser[0]);
                        n_err = n_err + 1;
                    end
                    if (m_tuser[1] !== want.sat) begin
                        $error("saturated exp %b got %b", want.sat, m_tuser[1]);
                        n_err = n_err + 1;
                    end
                    if (m_tuser[2] !== want.zdiv) begin
                        $error("zero_divisor exp %b got %b", want.zdiv, m_tuser[2]);
                        n_err = n_err + 1;
                    end
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    initial begin
        int n;
        n = 0;
        @(posedge i_rst_n);
        repeat (400) @(negedge i_clk);
        hold_rcv = 1'b1;
        while (n < 300) begin
            @(negedge i_clk);
            n++;
        end
        hold_rcv = 1'b0;
    end

    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam t_cplx_res   ZR   = '{32'd0, 32'd0, 1'b0, 1'b0, 1'b0};

    t_vec vecs[] = '{
        // add: saturation at both ends, plain sum
        '{ACT_ADD, PMAX, NMIN, 32'd1, NMIN, 1, '{PMAX, NMIN, 1'b0, 1'b1, 1'b0}},
        '{ACT_ADD, ONE, ONE, ONE, 32'hFFFF_0000, 1, '{32'h0002_0000, 32'd0, 0, 0, 0}},
        '{ACT_ADD, PMAX, PMAX, NMIN, NMIN, 1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0}},
        // equal test: match, real-only match, imaginary-only match
        '{ACT_EQ, NMIN, PMAX, NMIN, PMAX, 1, '{32'd0, 32'd0, 1'b1, 1'b0, 1'b0}},
        '{ACT_EQ, ONE, 32'd5, ONE, 32'd6, 1, ZR},
        '{ACT_EQ, 32'd7, ONE, 32'd8, ONE, 1, ZR},
        // modulus: zero, 3-4-5, saturation at the corners
        '{ACT_MOD, 32'd0, 32'd0, ONE, ONE, 1, ZR},
        '{ACT_MOD, 32'd3, 32'd4, 32'd0, 32'd0, 1, '{32'd5, 32'd0, 0, 0, 0}},
        '{ACT_MOD, NMIN, NMIN, 32'd0, 32'd0, 1, '{PMAX, 32'd0, 1'b0, 1'b1, 1'b0}},
        '{ACT_MOD, PMAX, 32'd0, 32'd0, 32'd0, 1, '{PMAX, 32'd0, 0, 0, 0}},
        '{ACT_MOD, NMIN, 32'd0, 32'd0, 32'd0, 0, ZR},
        // projection: zero divisor, sign, saturation
        '{ACT_PROJ, PMAX, NMIN, 32'd0, 32'd0, 1, '{32'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
        '{ACT_PROJ, 32'd6, 32'd8, 32'd3, 32'd4, 1, '{32'd10, 32'd0, 0, 0, 0}},
        '{ACT_PROJ, 32'hFFFF_FFFA, 32'hFFFF_FFF8, 32'd3, 32'd4, 1,
          '{32'hFFFF_FFF6, 32'd0, 0, 0, 0}},
        '{ACT_PROJ, NMIN, NMIN, NMIN, NMIN, 0, ZR},
        '{ACT_PROJ, NMIN, PMAX, 32'd1, 32'hFFFF_FFFF, 0, ZR},
        '{ACT_PROJ, PMAX, PMAX, 32'd1, 32'd0, 0, ZR},
        '{ACT_PROJ, NMIN, 32'd0, 32'd1, 32'd0, 0, ZR},
        '{ACT_PROJ, NMIN, NMIN, 32'd1, 32'd1, 0, ZR},
        '{ACT_PROJ, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd1, 0, ZR}
    };

    // Main sequence: reset, directed table, three random phases, drain.
    initial begin
        t_act act;
        int   n;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (vecs[k])
            send_item(vecs[k].act, vecs[k].ar, vecs[k].ai, vecs[k].br, vecs[k].bi,
                      vecs[k].chk, vecs[k].res);
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 68 : 0;
            rcv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 23 : 0;
            for (int k = 0; k < N_RAND / 3; k++) begin
                act = t_act'($urandom_range(0, 3));
                // equal test needs matching operands now and then
                if (act == ACT_EQ && $urandom_range(0, 1)) begin
                    logic [31:0] x, y;
                    x = rand_operand();
                    y = rand_operand();
                    send_item(act, x, y, x, $urandom_range(0, 1) ? y : rand_operand(),
                              0, ZR);
                end else begin
                    send_item(act, rand_operand(), rand_operand(), rand_operand(),
                              rand_operand(), 0, ZR);
                end
            end
        end
        s_tvalid <= 1'b0;
        n = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        while (n < 2 * PIPE_LAT) begin
            @(posedge i_clk);
            n++;
        end
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
